/* src/hhbu_pkg.sv */
package hhbu_pkg;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } in_item_t;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_INCREMENT = 3'd1,
        ACT_DECAY     = 3'd2,
        ACT_REPLACE   = 3'd3,
        ACT_UNCHANGED = 3'd4
    } action_t;

    typedef struct packed {
        action_t     action;
        logic [9:0]  bucket_index;
        logic [2:0]  cell_index;
        logic [31:0] count_after;
    } result_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HM1,
        ST_HM2,
        ST_HMIX,
        ST_FM1,
        ST_FM2,
        ST_FM3,
        ST_SRD,
        ST_SEV,
        ST_RLO,
        ST_RHI,
        ST_RADD,
        ST_RQ,
        ST_RM,
        ST_DEC
    } state_t;

    // sketch geometry, both powers of two
    localparam int          BUCKETS          = 1024;
    localparam int          CELLS_PER_BUCKET = 8;

    localparam logic [31:0] MM_C1    = 32'hCC9E2D51;
    localparam logic [31:0] MM_C2    = 32'h1B873593;
    localparam logic [31:0] MM_N     = 32'hE6546B64;
    localparam logic [31:0] MM_F1    = 32'h85EBCA6B;
    localparam logic [31:0] MM_F2    = 32'hC2B2AE35;
    localparam logic [31:0] MM_LEN   = 32'd13;
    localparam logic [31:0] LCG_MUL  = 32'd1103515245;
    localparam logic [63:0] LCG_INC  = 64'd12345;
    localparam logic [31:0] SEED_RST = 32'h9747B28C;
    localparam int          RAND_MOD = 10000;
    // x / RAND_MOD == (x * RAND_RECIP) >> RAND_SHIFT for any 32-bit x
    localparam logic [31:0] RAND_RECIP = 32'hD1B71759;
    localparam int          RAND_SHIFT = 45;
    localparam logic [31:0] CNT_MAX  = 32'hFFFFFFFF;
    localparam logic        REG_SEED = 1'b0;

    function automatic logic [13:0] decay_thr(input logic [31:0] c);
        logic [13:0] t;
        t = 14'd1;
        if (c < 32'd20)
        begin
            case (c[4:0])
                5'd0:    t = 14'd100;
                5'd1:    t = 14'd9259;
                5'd2:    t = 14'd8573;
                5'd3:    t = 14'd7942;
                5'd4:    t = 14'd7354;
                5'd5:    t = 14'd6810;
                5'd6:    t = 14'd6309;
                5'd7:    t = 14'd5841;
                5'd8:    t = 14'd5409;
                5'd9:    t = 14'd5010;
                5'd10:   t = 14'd4638;
                5'd11:   t = 14'd4295;
                5'd12:   t = 14'd3977;
                5'd13:   t = 14'd3683;
                5'd14:   t = 14'd3410;
                5'd15:   t = 14'd3158;
                5'd16:   t = 14'd2924;
                5'd17:   t = 14'd2707;
                5'd18:   t = 14'd2507;
                5'd19:   t = 14'd2321;
                default: t = 14'd1;
            endcase
        end
        return t;
    endfunction

endpackage

/* src/hhbu_mul.sv */
module hhbu_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;

endmodule

/* src/hhbu_mod.sv */
// Remainder by the random modulus through the shared multiplier, two passes:
// first prod = x * RAND_RECIP gives the quotient in prod's top bits,
// then prod = quotient * RAND_MOD and the remainder is x - prod.
module hhbu_mod (
    input  logic [30:0] dividend,
    input  logic [63:0] prod,
    output logic [31:0] quot,
    output logic [13:0] rem
);

    assign quot = 32'(prod[63:hhbu_pkg::RAND_SHIFT]);
    assign rem  = 14'({1'b0, dividend} - prod[31:0]);

endmodule

/* src/heavy_hitter_bucket_update.sv */
// Channel   Direction  Handshake                   Payload
// request   in         start & !busy               item   (hhbu_pkg::in_item_t)
// result    out        done, one cycle, no stall   result (hhbu_pkg::result_t)
// config    in         APB, psel&penable&pwrite    pwdata, paddr (seed at 0)
//
// Per request: the hash, then a read and an evaluate step for each cell
// scanned; a full bucket with no match then closes the scan and runs the LCG,
// the reciprocal remainder and the decay decision. The shared 32x32 multiplier
// serialises these steps. done follows in the cycle after the last busy one.
// After reset the count store is cleared, one entry a cycle, with busy high.
// Results cannot be stalled: done is high for exactly one cycle.
module heavy_hitter_bucket_update (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  hhbu_pkg::in_item_t  item,
    output logic                done,
    output hhbu_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int BUCKETS          = hhbu_pkg::BUCKETS;
    localparam int CELLS_PER_BUCKET = hhbu_pkg::CELLS_PER_BUCKET;
    localparam int TOTAL = BUCKETS * CELLS_PER_BUCKET;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CIW   = $clog2(CELLS_PER_BUCKET + 1);
    localparam int CXW   = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;

    hhbu_pkg::state_t state_reg, state_next;

    logic [31:0]        seed_reg;
    hhbu_pkg::in_item_t in_reg, in_next;
    logic [1:0]         word_reg, word_next;
    logic [31:0]        h_reg, h_next;
    logic [BW-1:0]      bucket_reg, bucket_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [CIW-1:0]     cidx_reg, cidx_next;
    logic [CXW-1:0]     min_idx_reg, min_idx_next;
    logic [31:0]        min_cnt_reg, min_cnt_next;
    logic [63:0]        rng_reg, rng_next;
    logic [63:0]        lo_reg, lo_next;
    logic               done_reg, done_next;
    hhbu_pkg::result_t  res_reg, res_next;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [31:0]   mod_quot;
    logic [13:0]   mod_rem;

    logic [103:0] key_mem [TOTAL];
    logic [31:0]  cnt_mem [TOTAL];
    logic [103:0] key_q;
    logic [31:0]  cnt_q;
    logic         rd_en, cnt_we, key_we;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]  cnt_wdata;
    logic [103:0] key_in;

    logic [31:0] word, k_rot, hx, hr, hf0, hf, t13, t16;
    logic        cfg_we;

    hhbu_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    hhbu_mod u_mod (
        .dividend (rng_reg[46:16]),
        .prod     (prod),
        .quot     (mod_quot),
        .rem      (mod_rem)
    );

    // configuration
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == hhbu_pkg::REG_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= hhbu_pkg::SEED_RST;
        end
        else if (cfg_we && paddr[2] == hhbu_pkg::REG_SEED)
        begin
            seed_reg <= pwdata;
        end
    end

    // murmur3 helpers
    always_comb
    begin
        case (word_reg)
            2'd0:    word = {in_reg.src_address[7:0], in_reg.src_address[15:8],
                             in_reg.src_address[23:16], in_reg.src_address[31:24]};
            2'd1:    word = {in_reg.dst_address[7:0], in_reg.dst_address[15:8],
                             in_reg.dst_address[23:16], in_reg.dst_address[31:24]};
            2'd2:    word = {in_reg.dst_port[7:0], in_reg.dst_port[15:8],
                             in_reg.src_port[7:0], in_reg.src_port[15:8]};
            default: word = {24'd0, in_reg.protocol};
        endcase
    end

    assign k_rot = {prod[16:0], prod[31:17]};
    assign hx    = h_reg ^ prod[31:0];
    assign hr    = {hx[18:0], hx[31:19]};
    assign hf0   = hx ^ hhbu_pkg::MM_LEN;
    assign hf    = hf0 ^ (hf0 >> 16);
    assign t13   = prod[31:0] ^ (prod[31:0] >> 13);
    assign t16   = prod[31:0] ^ (prod[31:0] >> 16);

    assign key_in = {in_reg.src_address, in_reg.dst_address, in_reg.src_port,
                     in_reg.dst_port, in_reg.protocol};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hhbu_pkg::ST_CLEAR:
                if (clr_reg == AW'(TOTAL - 1))
                    state_next = hhbu_pkg::ST_IDLE;
            hhbu_pkg::ST_IDLE:
                if (start)
                    state_next = hhbu_pkg::ST_HM1;
            hhbu_pkg::ST_HM1:
                state_next = hhbu_pkg::ST_HM2;
            hhbu_pkg::ST_HM2:
                state_next = hhbu_pkg::ST_HMIX;
            hhbu_pkg::ST_HMIX:
                state_next = (word_reg == 2'd3) ? hhbu_pkg::ST_FM1 : hhbu_pkg::ST_HM1;
            hhbu_pkg::ST_FM1:
                state_next = hhbu_pkg::ST_FM2;
            hhbu_pkg::ST_FM2:
                state_next = hhbu_pkg::ST_FM3;
            hhbu_pkg::ST_FM3:
                state_next = hhbu_pkg::ST_SRD;
            hhbu_pkg::ST_SRD:
                state_next = (cidx_reg == CIW'(CELLS_PER_BUCKET)) ? hhbu_pkg::ST_RLO
                                                                   : hhbu_pkg::ST_SEV;
            hhbu_pkg::ST_SEV:
                if (cnt_q == 32'd0 || key_q == key_in)
                    state_next = hhbu_pkg::ST_IDLE;
                else
                    state_next = hhbu_pkg::ST_SRD;
            hhbu_pkg::ST_RLO:
                state_next = hhbu_pkg::ST_RHI;
            hhbu_pkg::ST_RHI:
                state_next = hhbu_pkg::ST_RADD;
            hhbu_pkg::ST_RADD:
                state_next = hhbu_pkg::ST_RQ;
            hhbu_pkg::ST_RQ:
                state_next = hhbu_pkg::ST_RM;
            hhbu_pkg::ST_RM:
                state_next = hhbu_pkg::ST_DEC;
            hhbu_pkg::ST_DEC:
                state_next = hhbu_pkg::ST_IDLE;
            default:
                state_next = hhbu_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_next      = in_reg;
        word_next    = word_reg;
        h_next       = h_reg;
        bucket_next  = bucket_reg;
        base_next    = base_reg;
        addr_next    = addr_reg;
        clr_next     = clr_reg;
        cidx_next    = cidx_reg;
        min_idx_next = min_idx_reg;
        min_cnt_next = min_cnt_reg;
        rng_next     = rng_reg;
        lo_next      = lo_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        mul_a        = word;
        mul_b        = hhbu_pkg::MM_C1;
        rd_en        = 1'b0;
        rd_addr      = base_reg + AW'(cidx_reg[CXW-1:0]);
        cnt_we       = 1'b0;
        key_we       = 1'b0;
        wr_addr      = addr_reg;
        cnt_wdata    = 32'd1;
        case (state_reg)
            hhbu_pkg::ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                wr_addr   = clr_reg;
                cnt_wdata = 32'd0;
                clr_next  = clr_reg + AW'(1);
            end
            hhbu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    in_next   = item;
                    word_next = 2'd0;
                    h_next    = seed_reg;
                end
            end
            hhbu_pkg::ST_HM2:
            begin
                mul_a = k_rot;
                mul_b = hhbu_pkg::MM_C2;
            end
            hhbu_pkg::ST_HMIX:
            begin
                if (word_reg == 2'd3)
                    h_next = hf;
                else
                    h_next = {hr[29:0], 2'b00} + hr + hhbu_pkg::MM_N;
                word_next = word_reg + 2'd1;
            end
            hhbu_pkg::ST_FM1:
            begin
                mul_a = h_reg;
                mul_b = hhbu_pkg::MM_F1;
            end
            hhbu_pkg::ST_FM2:
            begin
                mul_a = t13;
                mul_b = hhbu_pkg::MM_F2;
            end
            hhbu_pkg::ST_FM3:
            begin
                // bucket count is a power of two: the remainder is the low bits
                h_next       = t16;
                bucket_next  = t16[BW-1:0];
                base_next    = AW'(AW'(t16[BW-1:0]) * AW'(CELLS_PER_BUCKET));
                cidx_next    = '0;
                min_idx_next = '0;
                min_cnt_next = hhbu_pkg::CNT_MAX;
            end
            hhbu_pkg::ST_SRD:
            begin
                if (cidx_reg != CIW'(CELLS_PER_BUCKET))
                begin
                    rd_en     = 1'b1;
                    addr_next = rd_addr;
                end
            end
            hhbu_pkg::ST_SEV:
            begin
                res_next.bucket_index = 10'(bucket_reg);
                res_next.cell_index   = 3'(cidx_reg);
                if (cnt_q == 32'd0)
                begin
                    cnt_we    = 1'b1;
                    key_we    = 1'b1;
                    cnt_wdata = 32'd1;
                    done_next = 1'b1;
                    res_next.action      = hhbu_pkg::ACT_INSERT;
                    res_next.count_after = 32'd1;
                end
                else if (key_q == key_in)
                begin
                    cnt_wdata = (cnt_q == hhbu_pkg::CNT_MAX) ? cnt_q : cnt_q + 32'd1;
                    cnt_we    = 1'b1;
                    done_next = 1'b1;
                    res_next.action      = hhbu_pkg::ACT_INCREMENT;
                    res_next.count_after = cnt_wdata;
                end
                else if (cnt_q < min_cnt_reg)
                begin
                    min_cnt_next = cnt_q;
                    min_idx_next = cidx_reg[CXW-1:0];
                end
                cidx_next = cidx_reg + CIW'(1);
            end
            hhbu_pkg::ST_RLO:
            begin
                mul_a = rng_reg[31:0];
                mul_b = hhbu_pkg::LCG_MUL;
            end
            hhbu_pkg::ST_RHI:
            begin
                mul_a   = rng_reg[63:32];
                mul_b   = hhbu_pkg::LCG_MUL;
                lo_next = prod;
            end
            hhbu_pkg::ST_RADD:
            begin
                rng_next  = lo_reg + {prod[31:0], 32'd0} + hhbu_pkg::LCG_INC;
                addr_next = base_reg + AW'(min_idx_reg);
            end
            hhbu_pkg::ST_RQ:
            begin
                mul_a = {1'b0, rng_reg[46:16]};
                mul_b = hhbu_pkg::RAND_RECIP;
            end
            hhbu_pkg::ST_RM:
            begin
                mul_a = mod_quot;
                mul_b = 32'(hhbu_pkg::RAND_MOD);
            end
            hhbu_pkg::ST_DEC:
            begin
                done_next = 1'b1;
                res_next.bucket_index = 10'(bucket_reg);
                res_next.cell_index   = 3'(min_idx_reg);
                if (mod_rem < hhbu_pkg::decay_thr(min_cnt_reg))
                begin
                    cnt_we = 1'b1;
                    if (min_cnt_reg > 32'd1)
                    begin
                        cnt_wdata = min_cnt_reg - 32'd1;
                        res_next.action = hhbu_pkg::ACT_DECAY;
                    end
                    else
                    begin
                        key_we    = 1'b1;
                        cnt_wdata = 32'd1;
                        res_next.action = hhbu_pkg::ACT_REPLACE;
                    end
                    res_next.count_after = cnt_wdata;
                end
                else
                begin
                    res_next.action      = hhbu_pkg::ACT_UNCHANGED;
                    res_next.count_after = min_cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hhbu_pkg::ST_CLEAR;
            clr_reg   <= '0;
            rng_reg   <= 64'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rng_reg   <= rng_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        word_reg    <= word_next;
        h_reg       <= h_next;
        bucket_reg  <= bucket_next;
        base_reg    <= base_next;
        addr_reg    <= addr_next;
        cidx_reg    <= cidx_next;
        min_idx_reg <= min_idx_next;
        min_cnt_reg <= min_cnt_next;
        lo_reg      <= lo_next;
        res_reg     <= res_next;
    end

    // bucket store
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[wr_addr] <= cnt_wdata;
        if (rd_en)
            cnt_q <= cnt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[wr_addr] <= key_in;
        if (rd_en)
            key_q <= key_mem[rd_addr];
    end

    assign busy   = (state_reg != hhbu_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on consecutive cycles");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hhbu_pkg::ST_CLEAR) |-> (!done && busy))
        else $error("activity during clearing pass");

    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> (cnt_we && cnt_wdata == 32'd1))
        else $error("key written without count of one");

endmodule
